// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the FIFO / stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Field widths fixed by the interface
  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned ERR_W = 2;
  localparam int unsigned OCC_W = 5;
  localparam int unsigned ENT_W = KEY_W + PAY_W;

  // Operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // Input beat
  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } spq_in_t;

  // Result beat
  typedef struct packed {
    logic             out_valid;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [ERR_W-1:0] error_code;
    logic [OCC_W-1:0] occupancy;
    logic             is_empty;
  } spq_out_t;

endpackage

// ===== rtl/spq_ram.sv =====
// Entry store: one write port, one registered read port.
`timescale 1ns / 1ps

module spq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/spq_seq.sv =====
// Queue sequencer: circular entry store, shared key comparator, scan/shift control.
`timescale 1ns / 1ps

module spq_seq
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IDX_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_in_t  in_data_i,
  input  logic     prio_mode_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output spq_out_t res_data_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEQ   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [PAY_W-1:0] pay_q, pay_d;
  spq_out_t         res_q, res_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  logic [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0] rd_pay;

  logic             is_full;
  logic             is_emp;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W:0]   idx_next;
  logic             key_less;

  // logical position -> physical slot, both operands below DEPTH
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (IDX_W+1)'(DEPTH)) begin
      s = s - (IDX_W+1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  spq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key = ram_rdata[ENT_W-1 -: KEY_W];
  assign rd_pay = ram_rdata[PAY_W-1:0];

  assign is_full  = (cnt_q == CNT_W'(DEPTH));
  assign is_emp   = (cnt_q == '0);
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign cnt_dec  = cnt_q - CNT_W'(1);
  assign last_idx = cnt_dec[IDX_W-1:0];
  assign idx_next = {1'b0, idx_q} + (IDX_W+1)'(1);

  // shared compare unit: new key strictly below the stored one
  assign key_less = (key_q < rd_key);

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_RESP);
  assign res_data_o  = res_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    key_d     = key_q;
    pay_d     = pay_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d = in_data_i.key;
          pay_d = in_data_i.payload;
          res_d = '0;
          res_d.occupancy = OCC_W'(cnt_q);
          res_d.is_empty  = is_emp;
          if (in_data_i.operation == OP_DEQ) begin
            if (is_emp) begin
              res_d.error_code = ERR_EMPTY;
              state_d = S_RESP;
            end else begin
              state_d = S_DEQ;
            end
          end else if (is_full) begin
            res_d.error_code = ERR_FULL;
            state_d = S_RESP;
          end else if (!prio_mode_i || is_emp) begin
            // append at the tail
            ram_we    = 1'b1;
            ram_waddr = wrap_add(head_q, cnt_q[IDX_W-1:0]);
            ram_wdata = {in_data_i.key, in_data_i.payload};
            cnt_d     = cnt_inc;
            res_d.occupancy = OCC_W'(cnt_inc);
            res_d.is_empty  = 1'b0;
            state_d   = S_RESP;
          end else begin
            idx_d   = '0;
            state_d = S_SCAN;
          end
        end
      end

      S_DEQ: begin
        res_d.out_valid   = 1'b1;
        res_d.out_key     = rd_key;
        res_d.out_payload = rd_pay;
        res_d.error_code  = ERR_OK;
        res_d.occupancy   = OCC_W'(cnt_dec);
        res_d.is_empty    = (cnt_dec == '0);
        head_d  = wrap_add(head_q, IDX_W'(1));
        cnt_d   = cnt_dec;
        state_d = S_RESP;
      end

      // read data holds entry idx_q; prefetch the next one
      S_SCAN: begin
        if (key_less) begin
          pos_d     = idx_q;
          idx_d     = last_idx;
          ram_raddr = wrap_add(head_q, last_idx);
          state_d   = S_SHIFT;
        end else if (idx_next == (IDX_W+1)'(cnt_q)) begin
          pos_d   = cnt_q[IDX_W-1:0];
          state_d = S_INS;
        end else begin
          idx_d     = idx_next[IDX_W-1:0];
          ram_raddr = wrap_add(head_q, idx_next[IDX_W-1:0]);
        end
      end

      // move entry idx_q up one slot, walking down to the insert point
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(head_q, idx_next[IDX_W-1:0]);
        ram_wdata = ram_rdata;
        if (idx_q == pos_q) begin
          state_d = S_INS;
        end else begin
          idx_d     = idx_q - IDX_W'(1);
          ram_raddr = wrap_add(head_q, idx_q - IDX_W'(1));
        end
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(head_q, pos_q);
        ram_wdata = {key_q, pay_q};
        cnt_d     = cnt_inc;
        res_d.occupancy = OCC_W'(cnt_inc);
        res_d.is_empty  = 1'b0;
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    pos_q <= pos_d;
    key_q <= key_d;
    pay_q <= pay_d;
    res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_we_states : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE || state_q == S_SHIFT || state_q == S_INS))
    else $error("store written outside an insert step");

  a_shift_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (idx_q >= pos_q && !is_full))
    else $error("shift walked below the insert point");

  a_deq_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEQ) |=> (state_q == S_RESP && res_q.out_valid))
    else $error("dequeue did not return an entry");
`endif

endmodule

// ===== rtl/fifo_or_stable_priority_queue.sv =====
// Top level: mode register, sequencer and output register of the queue.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+-----------
//   in      | input     | in_valid / ready   | spq_in_t
//   out     | output    | out_valid / ready  | spq_out_t
//   cfg     | input     | cfg_we, no wait    | priority_mode bit
//
// One item at a time. FIFO enqueue and errors go straight to the result state;
// a dequeue first reads the head entry; a priority enqueue scans for the first
// stored key above its own, shifts any later entries up a slot and inserts.
// Reset clears the count, head pointer, mode and output valid flag; entries are
// never read before they are written. The result waits in the output register
// so the next item can be accepted while it is stalled.
`timescale 1ns / 1ps

module fifo_or_stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_out_t out_data_o,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i
);

  logic     mode_q;
  logic     res_valid;
  logic     res_ready;
  spq_out_t res_data;
  logic     out_valid_q;
  spq_out_t out_q;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  spq_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .prio_mode_i (mode_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
